FILE: design/svpd_pkg.sv
package svpd_pkg;

    localparam int SQRT_STEPS = 24;
    localparam int DIV_STEPS  = 16;
    localparam int Q_W        = DIV_STEPS - 1;
    localparam int ROOT_W     = 48;
    localparam int MAG_W      = 24;
    localparam int P_W        = 36;
    localparam int NUM_W      = 58;
    localparam int DEN_W      = 42;
    localparam int T_W        = 17;
    localparam int NUM_SHIFT  = 22;

    localparam logic [16:0]    SQ3       = 17'd113512;
    localparam logic [T_W-1:0] FULL      = 17'd32768;
    localparam logic [15:0]    BUS_RESET = 16'd12000;

    localparam logic [2:0] SEC_1 = 3'd1;
    localparam logic [2:0] SEC_2 = 3'd2;
    localparam logic [2:0] SEC_3 = 3'd3;
    localparam logic [2:0] SEC_4 = 3'd4;
    localparam logic [2:0] SEC_5 = 3'd5;
    localparam logic [2:0] SEC_6 = 3'd6;

    typedef struct packed {
        logic signed [15:0] v_alpha;
        logic signed [15:0] v_beta;
    } vec_word_t;

    typedef struct packed {
        logic [2:0]  sector;
        logic [15:0] duty_u;
        logic [15:0] duty_v;
        logic [15:0] duty_w;
    } res_word_t;

    typedef struct packed {
        logic                  valid;
        logic [2:0]            sector;
        logic                  limited;
        logic [31:0]           m2;
        logic signed [P_W-1:0] p1;
        logic signed [P_W-1:0] p2;
    } proj_t;

    typedef struct packed {
        logic                  valid;
        logic [2:0]            sector;
        logic                  limited;
        logic [MAG_W-1:0]      mag;
        logic signed [P_W-1:0] p1;
        logic signed [P_W-1:0] p2;
    } mag_t;

endpackage

FILE: design/svpd_front.sv
module svpd_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                vec_valid,
    input  svpd_pkg::vec_word_t vec,
    input  logic [15:0]         bus,
    output svpd_pkg::proj_t     proj
);

    function automatic logic [2:0] sector_of_code(input logic [2:0] code);
        logic [2:0] s;
        case (code)
            3'd0:    s = svpd_pkg::SEC_1;
            3'd1:    s = svpd_pkg::SEC_2;
            3'd2:    s = svpd_pkg::SEC_6;
            3'd3:    s = svpd_pkg::SEC_1;
            3'd4:    s = svpd_pkg::SEC_4;
            3'd5:    s = svpd_pkg::SEC_3;
            3'd6:    s = svpd_pkg::SEC_5;
            default: s = svpd_pkg::SEC_1;
        endcase
        return s;
    endfunction

    logic               s1_valid_reg;
    logic signed [15:0] s1_va_reg, s1_vb_reg;
    logic [31:0]        s1_va2_reg, s1_vb2_reg, s1_bus2_reg;
    logic signed [33:0] s1_sq3vb_reg;
    logic               s1_bus0_reg;
    logic signed [31:0] va2_s, vb2_s;
    logic signed [33:0] sq3vb_next;
    logic [31:0]        bus2_next;

    always_comb
    begin
        va2_s      = vec.v_alpha * vec.v_alpha;
        vb2_s      = vec.v_beta * vec.v_beta;
        sq3vb_next = $signed({1'b0, svpd_pkg::SQ3}) * vec.v_beta;
        bus2_next  = 32'(bus) * 32'(bus);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= vec_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_va_reg    <= vec.v_alpha;
            s1_vb_reg    <= vec.v_beta;
            s1_va2_reg   <= unsigned'(va2_s);
            s1_vb2_reg   <= unsigned'(vb2_s);
            s1_sq3vb_reg <= sq3vb_next;
            s1_bus2_reg  <= bus2_next;
            s1_bus0_reg  <= (bus == 16'd0);
        end
    end

    logic                            s2_valid_reg, s2_zero_reg, s2_limited_reg;
    logic [2:0]                      s2_code_reg;
    logic [31:0]                     s2_m2_reg;
    logic signed [svpd_pkg::P_W-1:0] s2_x_reg, s2_y_reg, s2_z_reg;
    logic [31:0]                     m2;
    logic [33:0]                     m2x3, va2x3, vb2w;
    logic                            gt, lt, a_pos, a_neg, zero;
    logic                            va_lt0, va_gt0, va_ge0, va_le0, vb_lt0, vb_ge0;
    logic signed [svpd_pkg::P_W-1:0] sq3vb_w, va_w, va3;
    logic [2:0]                      code_next;

    always_comb
    begin
        m2    = s1_va2_reg + s1_vb2_reg;
        m2x3  = {2'b00, m2} + {1'b0, m2, 1'b0};
        va2x3 = {2'b00, s1_va2_reg} + {1'b0, s1_va2_reg, 1'b0};
        vb2w  = {2'b00, s1_vb2_reg};
        gt    = va2x3 > vb2w;
        lt    = va2x3 < vb2w;
        va_lt0 = s1_va_reg[15];
        va_gt0 = !s1_va_reg[15] && (s1_va_reg != 16'sd0);
        va_ge0 = !va_lt0;
        va_le0 = !va_gt0;
        vb_lt0 = s1_vb_reg[15];
        vb_ge0 = !vb_lt0;
        if (va_ge0 && vb_lt0)
            a_pos = 1'b1;
        else if (va_le0 && vb_ge0)
            a_pos = 1'b0;
        else if (va_gt0)
            a_pos = gt;
        else
            a_pos = lt;
        if (va_le0 && vb_lt0)
            a_neg = 1'b1;
        else if (va_ge0 && vb_ge0)
            a_neg = 1'b0;
        else if (va_lt0)
            a_neg = gt;
        else
            a_neg = lt;
        zero = s1_bus0_reg || (m2 == 32'd0);
        code_next = zero ? 3'd0
                  : {a_neg, a_pos, !vb_lt0 && (s1_vb_reg != 16'sd0)};
        sq3vb_w = {{(svpd_pkg::P_W-34){s1_sq3vb_reg[33]}}, s1_sq3vb_reg};
        va_w    = {{(svpd_pkg::P_W-16){s1_va_reg[15]}}, s1_va_reg};
        va3     = (va_w <<< 17) + (va_w <<< 16);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_zero_reg    <= zero;
            s2_limited_reg <= !s1_bus0_reg && (m2x3 > {2'b00, s1_bus2_reg});
            s2_code_reg    <= code_next;
            s2_m2_reg      <= m2;
            s2_x_reg       <= sq3vb_w <<< 1;
            s2_y_reg       <= va3 + sq3vb_w;
            s2_z_reg       <= sq3vb_w - va3;
        end
    end

    logic                            s3_valid_reg;
    svpd_pkg::proj_t                 s3_reg;
    logic [2:0]                      sector;
    logic signed [svpd_pkg::P_W-1:0] p1, p2;

    always_comb
    begin
        sector = sector_of_code(s2_code_reg);
        case (sector)
            svpd_pkg::SEC_1: begin p1 = -s2_z_reg; p2 = s2_x_reg;  end
            svpd_pkg::SEC_2: begin p1 = s2_y_reg;  p2 = s2_z_reg;  end
            svpd_pkg::SEC_3: begin p1 = s2_x_reg;  p2 = -s2_y_reg; end
            svpd_pkg::SEC_4: begin p1 = s2_z_reg;  p2 = -s2_x_reg; end
            svpd_pkg::SEC_5: begin p1 = -s2_y_reg; p2 = -s2_z_reg; end
            default:         begin p1 = -s2_x_reg; p2 = s2_y_reg;  end
        endcase
        if (s2_zero_reg)
        begin
            p1 = '0;
            p2 = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_reg.valid   <= 1'b1;
            s3_reg.sector  <= sector;
            s3_reg.limited <= s2_limited_reg;
            s3_reg.m2      <= s2_m2_reg;
            s3_reg.p1      <= p1;
            s3_reg.p2      <= p2;
        end
    end

    always_comb
    begin
        proj       = s3_reg;
        proj.valid = s3_valid_reg;
    end

endmodule

FILE: design/svpd_sqrt.sv
module svpd_sqrt (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  svpd_pkg::proj_t proj,
    output svpd_pkg::mag_t  mag
);

    localparam int N = svpd_pkg::SQRT_STEPS;
    localparam int W = svpd_pkg::ROOT_W;

    logic [W-1:0]    n_reg [N];
    logic [W-1:0]    root_reg [N];
    logic [W-1:0]    n_next [N];
    logic [W-1:0]    root_next [N];
    logic            valid_reg [N];
    svpd_pkg::proj_t side_reg [N];

    for (genvar g = 0; g < N; g++)
    begin : g_step
        logic [W-1:0]    n_in, root_in, bit_w, trial;
        logic            valid_in;
        svpd_pkg::proj_t side_in;

        if (g == 0)
        begin : g_first
            assign n_in     = {proj.m2, 16'b0};
            assign root_in  = '0;
            assign valid_in = proj.valid;
            assign side_in  = proj;
        end
        else
        begin : g_rest
            assign n_in     = n_reg[g-1];
            assign root_in  = root_reg[g-1];
            assign valid_in = valid_reg[g-1];
            assign side_in  = side_reg[g-1];
        end

        assign bit_w = W'(1) << (2 * (N - 1 - g));
        assign trial = root_in + bit_w;

        always_comb
        begin
            if (n_in >= trial)
            begin
                n_next[g]    = n_in - trial;
                root_next[g] = (root_in >> 1) + bit_w;
            end
            else
            begin
                n_next[g]    = n_in;
                root_next[g] = root_in >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[g] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[g] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[g]    <= n_next[g];
                root_reg[g] <= root_next[g];
                side_reg[g] <= side_in;
            end
        end
    end

    always_comb
    begin
        mag.valid   = valid_reg[N-1];
        mag.sector  = side_reg[N-1].sector;
        mag.limited = side_reg[N-1].limited;
        mag.mag     = root_reg[N-1][svpd_pkg::MAG_W-1:0];
        mag.p1      = side_reg[N-1].p1;
        mag.p2      = side_reg[N-1].p2;
    end

endmodule

FILE: design/svpd_div.sv
module svpd_div (
    input  logic                        clk,
    input  logic                        en,
    input  logic [svpd_pkg::NUM_W-1:0]  num,
    input  logic [svpd_pkg::DEN_W-1:0]  den,
    output logic [svpd_pkg::T_W-1:0]    quot
);

    localparam int N  = svpd_pkg::DIV_STEPS;
    localparam int NW = svpd_pkg::NUM_W;
    localparam int DW = svpd_pkg::DEN_W;
    localparam int QW = svpd_pkg::Q_W;

    logic [NW-1:0] rem_reg [N];
    logic [DW-1:0] den_reg [N];
    logic [QW-1:0] q_reg [N];
    logic          cap_reg [N];

    for (genvar g = 0; g < N; g++)
    begin : g_step
        logic [NW-1:0] rem_in, shifted, rem_next;
        logic [DW-1:0] den_in;
        logic [QW-1:0] q_in, q_next;
        logic          cap_in, cap_next;

        if (g == 0)
        begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign q_in   = '0;
            assign cap_in = 1'b0;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[g-1];
            assign den_in = den_reg[g-1];
            assign q_in   = q_reg[g-1];
            assign cap_in = cap_reg[g-1];
        end

        assign shifted = NW'(den_in) << (N - 1 - g);

        always_comb
        begin
            rem_next = rem_in;
            q_next   = q_in;
            cap_next = cap_in;
            if (g == 0)
            begin
                cap_next = rem_in >= shifted;
            end
            else if (!cap_in && (rem_in >= shifted))
            begin
                rem_next = rem_in - shifted;
                q_next   = q_in | (QW'(1) << (N - 1 - g));
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[g] <= rem_next;
                den_reg[g] <= den_in;
                q_reg[g]   <= q_next;
                cap_reg[g] <= cap_next;
            end
        end
    end

    assign quot = cap_reg[N-1] ? svpd_pkg::FULL : {2'b00, q_reg[N-1]};

endmodule

FILE: design/space_vector_pwm_duty_core.sv
// Space vector PWM duty generator: each word holds an alpha/beta voltage command in
// millivolts and yields one word with the sector (1 to 6) and the centered U/V/W duties
// in Q1.15, where 32768 is full on. Commands longer than bus_voltage/sqrt3 are scaled
// back onto that circle. The datapath is a 65-stage pipeline (a 24-stage square root
// and three 16-stage dividers, two of them side by side, one bit per stage), so it
// takes one word per clock unless stalled. A stall on the result side freezes the
// whole pipeline. Write cfg_wdata only while no word is in flight.
module space_vector_pwm_duty_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wen,
    input  logic [15:0]         cfg_wdata,
    input  logic                vec_valid,
    output logic                vec_stall,
    input  svpd_pkg::vec_word_t vec,
    output logic                res_valid,
    input  logic                res_stall,
    output svpd_pkg::res_word_t res
);

    localparam int ND  = svpd_pkg::DIV_STEPS;
    localparam int NW  = svpd_pkg::NUM_W;
    localparam int DW  = svpd_pkg::DEN_W;
    localparam int TW  = svpd_pkg::T_W;
    localparam int PW  = svpd_pkg::P_W;

    logic [15:0] bus_reg;
    logic        en;
    logic        res_valid_reg;
    svpd_pkg::res_word_t res_reg;

    assign en        = !res_valid_reg || !res_stall;
    assign vec_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_reg <= svpd_pkg::BUS_RESET;
        end
        else if (cfg_wen)
        begin
            bus_reg <= cfg_wdata;
        end
    end

    svpd_pkg::proj_t proj;
    svpd_pkg::mag_t  sq;

    svpd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .vec_valid (vec_valid),
        .vec       (vec),
        .bus       (bus_reg),
        .proj      (proj)
    );

    svpd_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .proj  (proj),
        .mag   (sq)
    );

    // Denominator of the dwell time division.
    logic                 d0_valid_reg, d0_limited_reg;
    logic [2:0]           d0_sector_reg;
    logic signed [PW-1:0] d0_p1_reg, d0_p2_reg;
    logic [DW-1:0]        d0_den_reg, d0_den_next;

    always_comb
    begin
        if (sq.limited)
            d0_den_next = DW'(svpd_pkg::SQ3) * DW'(sq.mag);
        else
            d0_den_next = DW'({bus_reg, 2'b00});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d0_valid_reg <= 1'b0;
        else if (en)
            d0_valid_reg <= sq.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d0_limited_reg <= sq.limited;
            d0_sector_reg  <= sq.sector;
            d0_p1_reg      <= sq.p1;
            d0_p2_reg      <= sq.p2;
            d0_den_reg     <= d0_den_next;
        end
    end

    // Rounded numerators.
    logic          d1_valid_reg, d1_pos1_reg, d1_pos2_reg;
    logic [2:0]    d1_sector_reg;
    logic [NW-1:0] d1_num1_reg, d1_num2_reg, d1_num1_next, d1_num2_next;
    logic [DW-1:0] d1_den_reg;
    logic          pos1, pos2;
    logic [NW-1:0] mag1, mag2;

    always_comb
    begin
        pos1 = !d0_p1_reg[PW-1] && (d0_p1_reg != '0);
        pos2 = !d0_p2_reg[PW-1] && (d0_p2_reg != '0);
        mag1 = NW'(d0_p1_reg[PW-2:0]);
        mag2 = NW'(d0_p2_reg[PW-2:0]);
        if (d0_limited_reg)
        begin
            mag1 = mag1 << svpd_pkg::NUM_SHIFT;
            mag2 = mag2 << svpd_pkg::NUM_SHIFT;
        end
        d1_num1_next = mag1 + NW'(d0_den_reg >> 1);
        d1_num2_next = mag2 + NW'(d0_den_reg >> 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d1_valid_reg <= 1'b0;
        else if (en)
            d1_valid_reg <= d0_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d1_pos1_reg   <= pos1;
            d1_pos2_reg   <= pos2;
            d1_sector_reg <= d0_sector_reg;
            d1_num1_reg   <= d1_num1_next;
            d1_num2_reg   <= d1_num2_next;
            d1_den_reg    <= d0_den_reg;
        end
    end

    logic [TW-1:0] q1, q2;

    svpd_div u_div_t1 (
        .clk  (clk),
        .en   (en),
        .num  (d1_num1_reg),
        .den  (d1_den_reg),
        .quot (q1)
    );

    svpd_div u_div_t2 (
        .clk  (clk),
        .en   (en),
        .num  (d1_num2_reg),
        .den  (d1_den_reg),
        .quot (q2)
    );

    logic       dl_valid_reg [ND];
    logic       dl_pos1_reg [ND];
    logic       dl_pos2_reg [ND];
    logic [2:0] dl_sector_reg [ND];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ND; i++)
                dl_valid_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            dl_valid_reg[0] <= d1_valid_reg;
            for (int i = 1; i < ND; i++)
                dl_valid_reg[i] <= dl_valid_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dl_pos1_reg[0]   <= d1_pos1_reg;
            dl_pos2_reg[0]   <= d1_pos2_reg;
            dl_sector_reg[0] <= d1_sector_reg;
            for (int i = 1; i < ND; i++)
            begin
                dl_pos1_reg[i]   <= dl_pos1_reg[i-1];
                dl_pos2_reg[i]   <= dl_pos2_reg[i-1];
                dl_sector_reg[i] <= dl_sector_reg[i-1];
            end
        end
    end

    // Clamped dwell times.
    logic          e0_valid_reg;
    logic [2:0]    e0_sector_reg;
    logic [TW-1:0] e0_t1_reg, e0_t2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e0_valid_reg <= 1'b0;
        else if (en)
            e0_valid_reg <= dl_valid_reg[ND-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e0_sector_reg <= dl_sector_reg[ND-1];
            e0_t1_reg     <= dl_pos1_reg[ND-1] ? q1 : '0;
            e0_t2_reg     <= dl_pos2_reg[ND-1] ? q2 : '0;
        end
    end

    // Renormalization setup when the two times overrun the period.
    logic          e1_valid_reg, e1_renorm_reg;
    logic [2:0]    e1_sector_reg;
    logic [TW-1:0] e1_t1_reg, e1_t2_reg, e1_sum;
    logic [NW-1:0] e1_num_reg, e1_num_next;
    logic [DW-1:0] e1_den_reg;

    always_comb
    begin
        e1_sum      = e0_t1_reg + e0_t2_reg;
        e1_num_next = (NW'(e0_t1_reg) << 15) + NW'(e1_sum >> 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e1_valid_reg <= 1'b0;
        else if (en)
            e1_valid_reg <= e0_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e1_renorm_reg <= e1_sum > svpd_pkg::FULL;
            e1_sector_reg <= e0_sector_reg;
            e1_t1_reg     <= e0_t1_reg;
            e1_t2_reg     <= e0_t2_reg;
            e1_num_reg    <= e1_num_next;
            e1_den_reg    <= DW'(e1_sum);
        end
    end

    logic [TW-1:0] qr;

    svpd_div u_div_renorm (
        .clk  (clk),
        .en   (en),
        .num  (e1_num_reg),
        .den  (e1_den_reg),
        .quot (qr)
    );

    logic          rl_valid_reg [ND];
    logic          rl_renorm_reg [ND];
    logic [2:0]    rl_sector_reg [ND];
    logic [TW-1:0] rl_t1_reg [ND];
    logic [TW-1:0] rl_t2_reg [ND];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ND; i++)
                rl_valid_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            rl_valid_reg[0] <= e1_valid_reg;
            for (int i = 1; i < ND; i++)
                rl_valid_reg[i] <= rl_valid_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rl_renorm_reg[0] <= e1_renorm_reg;
            rl_sector_reg[0] <= e1_sector_reg;
            rl_t1_reg[0]     <= e1_t1_reg;
            rl_t2_reg[0]     <= e1_t2_reg;
            for (int i = 1; i < ND; i++)
            begin
                rl_renorm_reg[i] <= rl_renorm_reg[i-1];
                rl_sector_reg[i] <= rl_sector_reg[i-1];
                rl_t1_reg[i]     <= rl_t1_reg[i-1];
                rl_t2_reg[i]     <= rl_t2_reg[i-1];
            end
        end
    end

    // Final times and the zero-vector half time.
    logic          e2_valid_reg;
    logic [2:0]    e2_sector_reg;
    logic [TW-1:0] e2_t1_reg, e2_t2_reg, e2_half_reg;
    logic [TW-1:0] t1f, t2f, t0f;

    always_comb
    begin
        if (rl_renorm_reg[ND-1])
        begin
            t1f = qr;
            t2f = svpd_pkg::FULL - qr;
        end
        else
        begin
            t1f = rl_t1_reg[ND-1];
            t2f = rl_t2_reg[ND-1];
        end
        t0f = svpd_pkg::FULL - t1f - t2f;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e2_valid_reg <= 1'b0;
        else if (en)
            e2_valid_reg <= rl_valid_reg[ND-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e2_sector_reg <= rl_sector_reg[ND-1];
            e2_t1_reg     <= t1f;
            e2_t2_reg     <= t2f;
            e2_half_reg   <= t0f >> 1;
        end
    end

    // Seven-segment phase duties.
    svpd_pkg::res_word_t res_next;
    logic [TW-1:0]       d_a, d_b, d_c, d_all;

    always_comb
    begin
        d_a   = e2_half_reg + e2_t1_reg;
        d_b   = e2_half_reg + e2_t2_reg;
        d_c   = e2_half_reg;
        d_all = e2_half_reg + e2_t1_reg + e2_t2_reg;
        res_next.sector = e2_sector_reg;
        case (e2_sector_reg)
            svpd_pkg::SEC_1:
            begin
                res_next.duty_u = d_all[15:0];
                res_next.duty_v = d_b[15:0];
                res_next.duty_w = d_c[15:0];
            end
            svpd_pkg::SEC_2:
            begin
                res_next.duty_u = d_a[15:0];
                res_next.duty_v = d_all[15:0];
                res_next.duty_w = d_c[15:0];
            end
            svpd_pkg::SEC_3:
            begin
                res_next.duty_u = d_c[15:0];
                res_next.duty_v = d_all[15:0];
                res_next.duty_w = d_b[15:0];
            end
            svpd_pkg::SEC_4:
            begin
                res_next.duty_u = d_c[15:0];
                res_next.duty_v = d_a[15:0];
                res_next.duty_w = d_all[15:0];
            end
            svpd_pkg::SEC_5:
            begin
                res_next.duty_u = d_b[15:0];
                res_next.duty_v = d_c[15:0];
                res_next.duty_w = d_all[15:0];
            end
            default:
            begin
                res_next.duty_u = d_all[15:0];
                res_next.duty_v = d_c[15:0];
                res_next.duty_w = d_a[15:0];
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (en)
            res_valid_reg <= e2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    a_sector_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.sector >= svpd_pkg::SEC_1 && res.sector <= svpd_pkg::SEC_6))
        else $error("sector out of range");

    a_duty_limit: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.duty_u <= 16'h8000 && res.duty_v <= 16'h8000
                       && res.duty_w <= 16'h8000))
        else $error("duty above full scale");

    a_times_fit: assert property (@(posedge clk) disable iff (!rst_n)
        e2_valid_reg |-> ({1'b0, e2_t1_reg} + {1'b0, e2_t2_reg} <= {1'b0, svpd_pkg::FULL}))
        else $error("active times exceed the period");

endmodule
